[rtl/core/rrps_pkg.sv]
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared constants and types of the round-robin pair scheduler.
// ----------------------------------------------------------------------------
package rrps_pkg;

  localparam int MAX_PLAYERS = 128;
  localparam int ADDR_W      = $clog2(MAX_PLAYERS);
  localparam int CNT_W       = $clog2(MAX_PLAYERS + 1);
  localparam int PAD_W       = $clog2(MAX_PLAYERS + 2);
  localparam int PTR_W       = CNT_W;

  localparam int ID_W        = 15;
  localparam int PLAYER_W    = 16;
  localparam int ROUND_W     = 7;
  localparam int OP_W        = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;

  localparam logic [OP_W-1:0]     OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0]     OP_ROUND = 2'd1;
  localparam logic [OP_W-1:0]     OP_CLEAR = 2'd2;

  localparam logic [PLAYER_W-1:0] BYE_CODE = 16'hFFFF;

  // Request to the shared pointer stepper.
  typedef struct packed {
    logic [PTR_W-1:0] ptr_a;
    logic [PTR_W-1:0] ptr_b;
    logic             hold_a;
    logic [PTR_W-1:0] span;
    logic [CNT_W-1:0] count;
  } ptr_req_t;

  // Stepped pointers, the table indices they select and bye flags.
  typedef struct packed {
    logic [PTR_W-1:0] ptr_a;
    logic [PTR_W-1:0] ptr_b;
    logic [CNT_W-1:0] idx_a;
    logic [CNT_W-1:0] idx_b;
    logic             bye_a;
    logic             bye_b;
  } ptr_rsp_t;

endpackage

[rtl/core/rrps_table.sv]
// ----------------------------------------------------------------------------
// rrps_table
// Player identifier memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rrps_table
  import rrps_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ID_W-1:0]   wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [ID_W-1:0]   rdata_a_o,
  output logic [ID_W-1:0]   rdata_b_o
);

  logic [ID_W-1:0] mem [MAX_PLAYERS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

[rtl/core/rrps_ptr_step.sv]
// ----------------------------------------------------------------------------
// rrps_ptr_step
// Shared modular stepper: advance or hold the front pointer, retreat the back
// pointer, both modulo the rotation span, and flag entries that fall on the bye.
// ----------------------------------------------------------------------------
module rrps_ptr_step
  import rrps_pkg::*;
(
  input  ptr_req_t req_i,
  output ptr_rsp_t rsp_o
);

  logic [PTR_W-1:0] last_ptr;

  always_comb begin
    last_ptr = req_i.span - PTR_W'(1);

    if (req_i.hold_a) begin
      rsp_o.ptr_a = req_i.ptr_a;
    end else if (req_i.ptr_a == last_ptr) begin
      rsp_o.ptr_a = '0;
    end else begin
      rsp_o.ptr_a = req_i.ptr_a + PTR_W'(1);
    end

    if (req_i.ptr_b == '0) begin
      rsp_o.ptr_b = last_ptr;
    end else begin
      rsp_o.ptr_b = req_i.ptr_b - PTR_W'(1);
    end

    // Entry k of the rotating list sits at table index k + 1.
    rsp_o.idx_a = CNT_W'(rsp_o.ptr_a) + CNT_W'(1);
    rsp_o.idx_b = CNT_W'(rsp_o.ptr_b) + CNT_W'(1);
    rsp_o.bye_a = (rsp_o.idx_a >= req_i.count);
    rsp_o.bye_b = (rsp_o.idx_b >= req_i.count);
  end

endmodule

[rtl/core/round_robin_pair_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_pair_scheduler
// Circle-method round-robin schedule builder with a stream request channel,
// a stream match channel and an APB register for side flipping.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is the op (load, round, clear), tdata the
//   player identifier. Load appends to the player table, clear empties it;
//   both rewind the rotation.
//   A round request with players loaded emits count/2 (rounded up) matches
//   on m_axis, one per beat, tlast on the final match of the round. Matches
//   leave at one per cycle while the receiver takes them, after a registered
//   table read; the dual-port table read and the shared pointer stepper allow
//   that rate. s_axis_tready is low while a round is being emitted and high
//   otherwise, also while the last match still waits.
//   A receiver stall holds the match register and freezes the sequencer.
//   Register 0 (address 0) is flip_start: bit 0 swaps the sides of each match.
//   Write it only while no round is running.
//   Reset clears the player count, the rotation, flip_start and the output
//   valid; the table keeps its contents, and only loaded entries are used.
// ----------------------------------------------------------------------------
module round_robin_pair_scheduler
  import rrps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [14:0] player_id, [15] zero
  input  logic [OP_W-1:0]       s_axis_tuser,   // [1:0] op
  // matches
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] first_player,
                                                // [31:16] second_player,
                                                // [38:32] round_number, [39] zero
  output logic                  m_axis_tlast,   // last_match
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                  state_q, state_d;
  logic [CNT_W-1:0]      count_q;
  logic [PTR_W-1:0]      rotation_q;
  logic [PTR_W-1:0]      pa_q, pb_q;
  logic [PTR_W-1:0]      j_q;
  logic                  bye_a_q, bye_b_q;
  logic [ID_W-1:0]       player0_q;
  logic                  flip_q;
  logic                  m_valid_q;
  logic                  m_last_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic                  in_fire, start, fire, out_free, last;
  logic                  do_load, do_clear, reg_sel, tbl_we;
  logic [OP_W-1:0]       op;
  logic [PAD_W-1:0]      padded;
  logic [PTR_W-1:0]      span, games;
  logic [ID_W-1:0]       rd_a, rd_b;
  logic [PLAYER_W-1:0]   side_a, side_b, first_p, second_p;
  ptr_req_t              preq;
  ptr_rsp_t              prsp;

  // ---- configuration port -------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {31'd0, flip_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      flip_q <= pwdata[0];
    end
  end

  // ---- request decode -----------------------------------------------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser;
  assign do_load       = in_fire && (op == OP_LOAD);
  assign do_clear      = in_fire && (op == OP_CLEAR);
  assign start         = in_fire && (op == OP_ROUND) && (count_q != '0);
  // Drop loads into a full table; the rotation still rewinds.
  assign tbl_we        = do_load && (count_q != CNT_W'(MAX_PLAYERS));

  // Pad an odd count with the bye; span is the length of the rotating list.
  assign padded = PAD_W'(count_q) + PAD_W'(count_q[0]);
  assign span   = PTR_W'(padded - PAD_W'(1));
  assign games  = PTR_W'(padded >> 1);

  // ---- sequencer ----------------------------------------------------------
  assign out_free = !m_valid_q || m_axis_tready;
  assign fire     = (state_q == ST_EMIT) && out_free;
  assign last     = (j_q == games - PTR_W'(1));

  // At round start both pointers come from the rotation: the front one holds,
  // the back one retreats to rotation - 1. During emission step them per match;
  // the front pointer holds across the fixed player's match.
  always_comb begin
    preq.span  = span;
    preq.count = count_q;
    if (state_q == ST_IDLE) begin
      preq.ptr_a  = rotation_q;
      preq.ptr_b  = rotation_q;
      preq.hold_a = 1'b1;
    end else begin
      preq.ptr_a  = pa_q;
      preq.ptr_b  = pb_q;
      preq.hold_a = (j_q == '0);
    end
  end

  rrps_ptr_step u_step (
    .req_i (preq),
    .rsp_o (prsp)
  );

  rrps_table u_table (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (count_q[ADDR_W-1:0]),
    .wdata_i   (s_axis_tdata[ID_W-1:0]),
    .re_i      (start || fire),
    .raddr_a_i (prsp.idx_a[ADDR_W-1:0]),
    .raddr_b_i (prsp.idx_b[ADDR_W-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (fire && last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      rotation_q <= '0;
      j_q        <= '0;
    end else begin
      state_q <= state_d;
      if (do_clear) begin
        count_q    <= '0;
        rotation_q <= '0;
      end else if (do_load) begin
        rotation_q <= '0;
        if (tbl_we) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (start) begin
        j_q <= '0;
      end else if (fire) begin
        j_q <= j_q + PTR_W'(1);
        if (last) begin
          rotation_q <= (rotation_q == span - PTR_W'(1)) ? '0 : rotation_q + PTR_W'(1);
        end
      end
    end
  end

  // Pointers, bye flags and the fixed player need no reset.
  always_ff @(posedge clk_i) begin
    if (start || fire) begin
      pa_q    <= prsp.ptr_a;
      pb_q    <= prsp.ptr_b;
      bye_a_q <= prsp.bye_a;
      bye_b_q <= prsp.bye_b;
    end
    if (tbl_we && (count_q == '0)) begin
      player0_q <= s_axis_tdata[ID_W-1:0];
    end
  end

  // ---- match assembly and output register ---------------------------------
  always_comb begin
    if (j_q == '0) begin
      side_a = {1'b0, player0_q};
    end else if (bye_a_q) begin
      side_a = BYE_CODE;
    end else begin
      side_a = {1'b0, rd_a};
    end
    side_b   = bye_b_q ? BYE_CODE : {1'b0, rd_b};
    first_p  = flip_q ? side_b : side_a;
    second_p = flip_q ? side_a : side_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      m_data_q <= {1'b0, ROUND_W'(rotation_q), second_p, first_p};
      m_last_q <= last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

[rtl/core/rrps_checker.sv]
// ----------------------------------------------------------------------------
// rrps_checker
// Port-level checks of the round-robin pair scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rrps_checker
  import rrps_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // A stalled match stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("match dropped while stalled");

  // A stalled match keeps its payload.
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("match payload changed while stalled");

  // No request is taken while a round is still being emitted.
  a_busy_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request accepted in the middle of a round");

  // Only one bye exists, so a match never pairs it with itself.
  a_single_bye: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !((m_axis_tdata[15:0] == BYE_CODE) &&
                        (m_axis_tdata[31:16] == BYE_CODE)))
    else $error("match of bye against bye");

endmodule

bind round_robin_pair_scheduler rrps_checker u_rrps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/round_robin_pair_scheduler_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_pair_scheduler_checker
// Watches the request, match and register channels of the pair scheduler,
// rebuilds each round by the circle method and compares every match beat.
// ----------------------------------------------------------------------------
module round_robin_pair_scheduler_checker
  import rrps_pkg::*;
#(
  parameter logic [2:0] FLIP_START_ADDR = 3'd0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [OP_W-1:0]       s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    mismatch_count,
  output int                    matches_owed
);

  typedef struct packed {
    logic [PLAYER_W-1:0] home;
    logic [PLAYER_W-1:0] away;
    logic [ROUND_W-1:0]  round_idx;
    logic                last;
  } match_t;

  logic [ID_W-1:0] roster [MAX_PLAYERS];
  int              seated;
  int              rotation;
  logic            flip;
  match_t          owed_q [$];
  int              misses;

  // Seat k of the rotating list; seats past the loaded players are the bye.
  function automatic logic [PLAYER_W-1:0] rotating_seat(input int k);
    int slot;
    slot = k + 1;
    if (slot < seated) return {1'b0, roster[slot]};
    return BYE_CODE;
  endfunction

  function automatic void schedule_round();
    int                  padded;
    int                  span;
    int                  games;
    int                  r;
    int                  j;
    logic [PLAYER_W-1:0] a;
    logic [PLAYER_W-1:0] b;
    logic [PLAYER_W-1:0] t;
    match_t              m;
    padded = seated + (seated % 2);
    span   = padded - 1;
    games  = padded / 2;
    r      = rotation % span;
    for (j = 0; j < games; j++) begin
      if (j == 0) begin
        a = {1'b0, roster[0]};
        b = rotating_seat((padded - 2 + r) % span);
      end else begin
        a = rotating_seat((j - 1 + r) % span);
        b = rotating_seat((padded - 2 - j + r) % span);
      end
      if (flip) begin
        t = a;
        a = b;
        b = t;
      end
      m.home      = a;
      m.away      = b;
      m.round_idx = r[ROUND_W-1:0];
      m.last      = (j + 1 == games);
      owed_q.insert(owed_q.size(), m);
    end
    rotation = (r + 1) % span;
  endfunction

  function automatic void note_mismatch(input bit stray, input match_t want,
                                        input match_t got);
    misses++;
    if (misses <= 10) begin
      if (stray)
        $display("[%0t] match with none owed: got %0d vs %0d round %0d last %0b",
                 $realtime, $signed(got.home), $signed(got.away), got.round_idx,
                 got.last);
      else begin
        $display("[%0t] match differs: want %0d vs %0d round %0d last %0b",
                 $realtime, $signed(want.home), $signed(want.away), want.round_idx,
                 want.last);
        $display("[%0t]                got  %0d vs %0d round %0d last %0b",
                 $realtime, $signed(got.home), $signed(got.away), got.round_idx,
                 got.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    match_t got;
    match_t want;
    if (!rst_ni) begin
      seated   = 0;
      rotation = 0;
      flip     = 1'b0;
      misses   = 0;
      owed_q.delete();
      mismatch_count <= 0;
      matches_owed   <= 0;
    end else begin
      // Check the outgoing match first: it always belongs to an older request.
      if (m_axis_tvalid && m_axis_tready) begin
        got.home      = m_axis_tdata[PLAYER_W-1:0];
        got.away      = m_axis_tdata[2*PLAYER_W-1:PLAYER_W];
        got.round_idx = m_axis_tdata[2*PLAYER_W +: ROUND_W];
        got.last      = m_axis_tlast;
        if (owed_q.size() == 0) begin
          note_mismatch(1'b1, got, got);
        end else begin
          want = owed_q.pop_front();
          if (got.home !== want.home || got.away !== want.away ||
              got.round_idx !== want.round_idx || got.last !== want.last)
            note_mismatch(1'b0, want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OP_LOAD: begin
            if (seated < MAX_PLAYERS) begin
              roster[seated] = s_axis_tdata[ID_W-1:0];
              seated++;
            end
            rotation = 0;
          end
          OP_CLEAR: begin
            seated   = 0;
            rotation = 0;
          end
          OP_ROUND: begin
            if (seated != 0) schedule_round();
          end
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready && paddr == FLIP_START_ADDR)
        flip = pwdata[0];
      mismatch_count <= misses;
      matches_owed   <= owed_q.size();
    end
  end

endmodule

[tb/tb_round_robin_pair_scheduler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_pair_scheduler
// Drives load, round and clear requests plus flip_start writes into the pair
// scheduler under random idling on both streams; a checker module beside the
// block predicts every match and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_round_robin_pair_scheduler;
  import rrps_pkg::*;

  // Op code the block leaves unused; requests with it must vanish silently.
  localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
  // Register 0 sits at byte address 0.
  localparam logic [2:0]      FLIP_START_ADDR = 3'd0;
  localparam int              ITEM_TARGET     = 360;
  // A round holds at most 64 matches plus the table read; allow some slack.
  localparam int              SETTLE_CYCLES   = 80;
  localparam int              HOLD_OFF_CYCLES = 400;
  localparam int              IDLE_PERCENT    = 17;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int                    mismatch_count;
  int                    matches_owed;
  int unsigned           requests_sent;
  // Raise to switch off idling on both streams for a while.
  bit                    steady;
  // The stimulus bumps asks, the receiver bumps served once a hold-off is done.
  int unsigned           hold_off_asks;
  int unsigned           hold_off_served;
  int unsigned           league;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  round_robin_pair_scheduler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [14:0] player_id, [15] zero
    .s_axis_tuser  (s_axis_tuser),   // [1:0] op
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] first, [31:16] second, [38:32] round
    .m_axis_tlast  (m_axis_tlast),   // last_match
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  round_robin_pair_scheduler_checker #(
    .FLIP_START_ADDR (FLIP_START_ADDR)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .matches_owed   (matches_owed)
  );

  // Give up long after the slowest correct run would have finished.
  initial begin
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Match receiver: random stalls, idle-free while steady, and one long
  // hold-off on request so the block backs up into the request stream.
  initial begin
    hold_off_served = 0;
    forever begin
      if (hold_off_asks != hold_off_served) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_served++;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom_range(32767));
  endfunction

  // Offer one request, idling first at random; return at the accepting edge
  // with tvalid still high so back-to-back requests need no extra step.
  task automatic send_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] pid);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, pid};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Drop the request stream, wait out every owed match, then let the block
  // settle in case the last request produced no match at all.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (matches_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Two-phase register write; junk in the upper bits must be ignored.
  task automatic write_flip(input logic value);
    logic [31:0] word;
    word    = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FLIP_START_ADDR;
    pwdata  <= {word[31:1], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Well-formed small league with random ids, sprinkled with noise: rounds on
  // an empty table, unused op codes and late loads that rewind the rotation.
  task automatic run_small_league();
    int unsigned field;
    int unsigned rounds;
    int unsigned roll;
    send_req(OP_CLEAR, rand_id());
    if ($urandom_range(99) < 15) send_req(OP_ROUND, rand_id());
    field = $urandom_range(1, 12);
    repeat (field) send_req(OP_LOAD, rand_id());
    rounds = $urandom_range(1, field + 2);
    repeat (rounds) begin
      roll = $urandom_range(99);
      if (roll < 8)
        send_req(OP_UNUSED, rand_id());
      else if (roll < 14)
        send_req(OP_LOAD, rand_id());
      send_req(OP_ROUND, rand_id());
    end
  endtask

  // Fill the table past capacity, then stall the receiver while rounds of
  // 64 matches keep coming so the block backs up and stalls its input.
  task automatic run_full_league();
    send_req(OP_CLEAR, rand_id());
    repeat (MAX_PLAYERS + 2) send_req(OP_LOAD, rand_id());
    hold_off_asks++;
    repeat (3) send_req(OP_ROUND, rand_id());
    // Load into a full table: dropped, but the rotation still rewinds.
    send_req(OP_LOAD, rand_id());
    send_req(OP_ROUND, rand_id());
  endtask

  initial begin
    requests_sent = 0;
    hold_off_asks = 0;
    steady        = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOAD;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= FLIP_START_ADDR;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: empty table, unused op, single player against the
    // bye, two players stuck at round 0, odd padding wrap, even league, clear.
    send_req(OP_ROUND, 15'h7FFF);
    send_req(OP_UNUSED, 15'h7FFF);
    send_req(OP_LOAD, 15'h7FFF);
    repeat (2) send_req(OP_ROUND, 15'h0000);
    send_req(OP_LOAD, 15'h0000);
    repeat (3) send_req(OP_ROUND, 15'h7FFF);
    send_req(OP_LOAD, 15'h5555);
    repeat (4) send_req(OP_ROUND, 15'h2AAA);
    send_req(OP_LOAD, 15'h2AAA);
    repeat (2) send_req(OP_ROUND, 15'h5555);
    send_req(OP_CLEAR, 15'h0000);
    send_req(OP_ROUND, 15'h7FFF);
    drain();

    // Random leagues, each under its own flip setting; both values come early.
    league = 0;
    while (requests_sent < ITEM_TARGET) begin
      if (league == 0)
        write_flip(1'b1);
      else if (league == 1)
        write_flip(1'b0);
      else
        write_flip(1'($urandom_range(1)));
      steady = (league >= 4 && league <= 6);
      if (league == 2)
        run_full_league();
      else
        run_small_league();
      drain();
      league++;
    end

    if (mismatch_count == 0 && matches_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
